FILE: rtl/hotp_code_generator_top_macros.svh
// Assertion macros for the HOTP code generator
`ifndef HOTP_CODE_GENERATOR_TOP_MACROS_SVH
`define HOTP_CODE_GENERATOR_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define HOTP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hotp assertion failed");
// next-cycle implication checked outside reset
`define HOTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hotp assertion failed");
`endif

FILE: rtl/hotp_pkg.sv
// Package: types and constants for the HOTP code generator
package hotp_pkg;
   localparam int KEY_BYTES   = 20;
   localparam int CTR_W       = 64;
   localparam int CODE_W      = 27;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] REG_KEY0   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY1   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY2   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIGITS = 2'd3;

   localparam logic [159:0] SHA1_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
   localparam logic [CODE_W-1:0] MOD6 = 27'd1000000;
   localparam logic [CODE_W-1:0] MOD8 = 27'd100000000;

   // reciprocals: q = (n * MAGIC) >> MUL_SHIFT is exact for n < 2^31
   localparam logic [31:0] MAGIC6     = 32'h431BDE83;
   localparam logic [31:0] MAGIC8     = 32'd2882303762;
   localparam int          MUL_SHIFT6 = 50;
   localparam int          MUL_SHIFT8 = 58;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD_I1, ST_RUN_I1, ST_LOAD_I2, ST_RUN_I2,
      ST_LOAD_O1, ST_RUN_O1, ST_LOAD_O2, ST_RUN_O2,
      ST_TRUNC, ST_REDUCE, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MP_IDLE, MP_MUL, MP_QUO, MP_SUB
   } mod_phase_type;

   function automatic logic [7:0] key_byte(input logic [159:0] key, input int i);
      logic [7:0] b;
      b = 8'h00;
      if (i < KEY_BYTES && i < 20) b = key[159 - 8*i -: 8];
      return b;
   endfunction

   function automatic logic [511:0] pad_block(input logic [159:0] key,
                                              input logic [7:0] pad);
      logic [511:0] blk;
      blk = '0;
      for (int i = 0; i < 64; i++) blk[511 - 8*i -: 8] = key_byte(key, i) ^ pad;
      return blk;
   endfunction
endpackage

FILE: rtl/hotp_if.sv
// Valid/ready channel interface
interface hotp_if #(parameter int WIDTH = 64) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/hotp_sha1_core.sv
// SHA-1 compression unit: one round per cycle, 16-word schedule window
module hotp_sha1_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [159:0] h_init,
   input  logic [511:0] block,
   output logic         done,
   output logic [159:0] h_out
);
   import hotp_pkg::*;
   logic [511:0] w_ff, w_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff, a_in, b_in, c_in, d_in, e_in;
   logic [159:0] h_ff, h_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  f, k, t, wt, wn;

   always_comb begin
      wt = w_ff[511:480];
      wn = w_ff[95:64] ^ w_ff[255:224] ^ w_ff[447:416] ^ w_ff[511:480];
      wn = {wn[30:0], wn[31]};
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'hCA62C1D6;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wt;
      w_in = w_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff; rnd_in = rnd_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         w_in = block; h_in = h_init;
         a_in = h_init[159:128]; b_in = h_init[127:96]; c_in = h_init[95:64];
         d_in = h_init[63:32]; e_in = h_init[31:0];
         rnd_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         w_in = {w_ff[479:0], wn};
         e_in = d_ff; d_in = c_ff; c_in = {b_ff[1:0], b_ff[31:2]}; b_in = a_ff; a_in = t;
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd79) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; rnd_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; rnd_ff <= rnd_in;
      end
      w_ff <= w_in; h_ff <= h_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
   end

   assign done  = done_ff;
   assign h_out = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                   h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
endmodule

FILE: rtl/hotp_mod_unit.sv
// Modulo 10^6 / 10^8 unit: reciprocal multiply, quotient times divisor, subtract
module hotp_mod_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,
   input  logic        use_mod8,
   output logic        done,
   output logic [26:0] remainder
);
   import hotp_pkg::*;
   logic [30:0]   dvd_ff, dvd_in;
   logic          m8_ff, m8_in;
   logic [62:0]   prod_ff, prod_in;
   logic [38:0]   qd_ff, qd_in;
   logic [26:0]   rem_ff, rem_in;
   mod_phase_type phase_ff, phase_in;
   logic          done_ff, done_in;
   logic [11:0]   quo;
   logic [26:0]   dvs;
   logic [31:0]   magic;
   logic [30:0]   diff;

   always_comb begin
      magic = m8_ff ? MAGIC8 : MAGIC6;
      dvs   = m8_ff ? MOD8 : MOD6;
      quo   = m8_ff ? {7'd0, prod_ff[MUL_SHIFT8 +: 5]} : prod_ff[MUL_SHIFT6 +: 12];
      diff  = dvd_ff - qd_ff[30:0];
      dvd_in = dvd_ff; m8_in = m8_ff; prod_in = prod_ff; qd_in = qd_ff; rem_in = rem_ff;
      phase_in = phase_ff; done_in = 1'b0;
      unique case (phase_ff)
         MP_IDLE: if (start) begin
            dvd_in = dividend; m8_in = use_mod8; phase_in = MP_MUL;
         end
         MP_MUL: begin
            prod_in = 63'(dvd_ff) * 63'(magic); phase_in = MP_QUO;
         end
         MP_QUO: begin
            qd_in = 39'(quo) * 39'(dvs); phase_in = MP_SUB;
         end
         MP_SUB: begin
            rem_in = diff[26:0]; done_in = 1'b1; phase_in = MP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MP_IDLE; done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; done_ff <= done_in;
      end
      dvd_ff <= dvd_in; m8_ff <= m8_in; prod_ff <= prod_in; qd_ff <= qd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

FILE: rtl/hotp_code_generator_top.sv
// HOTP code generator: an item is accepted, then runs four SHA-1 compressions
// (load, 80 rounds, done) on the one shared round unit, one truncation step and
// the reciprocal-multiply modulo (multiply, quotient, subtract) before the result
// is held. An invalid digit count skips the modulo and gives a zero code. One
// item at a time; the request channel is not ready until the result has been
// taken.
`include "hotp_code_generator_top_macros.svh"
module hotp_code_generator_top (
   input  logic clock,
   input  logic reset,
   hotp_if.sink   req,
   hotp_if.source rsp,
   input  logic                               csr_write_enable,
   input  logic [hotp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hotp_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import hotp_pkg::*;
   logic [63:0]  key0_ff, key1_ff;
   logic [31:0]  key2_ff;
   logic [3:0]   digits_ff;
   state_type    state_ff, state_in;
   logic [63:0]  ctr_ff, ctr_in;
   logic [159:0] hv_ff, hv_in, inner_ff, inner_in;
   logic [26:0]  code_ff, code_in;
   logic         sha_start, sha_done;
   logic         mod_start, mod_done, mod_use8;
   logic [511:0] blk;
   logic [159:0] sha_h_in, sha_h_out, key;
   logic [26:0]  mod_rem;
   logic [3:0]   off;
   logic [159:0] shifted;

   assign key = {key0_ff, key1_ff, key2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0; digits_ff <= 4'd6;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_KEY0:   key0_ff   <= csr_write_data;
            REG_KEY1:   key1_ff   <= csr_write_data;
            REG_KEY2:   key2_ff   <= csr_write_data[31:0];
            REG_DIGITS: digits_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   hotp_sha1_core u_sha (
      .clock(clock), .reset(reset), .start(sha_start), .h_init(sha_h_in),
      .block(blk), .done(sha_done), .h_out(sha_h_out));

   assign mod_use8 = (digits_ff == 4'd8);
   hotp_mod_unit u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(shifted[158:128]),
      .use_mod8(mod_use8), .done(mod_done), .remainder(mod_rem));

   always_comb begin
      state_in = state_ff; ctr_in = ctr_ff; hv_in = hv_ff; inner_in = inner_ff;
      code_in = code_ff;
      sha_start = 1'b0; mod_start = 1'b0;
      sha_h_in = hv_ff; blk = '0;
      off = hv_ff[3:0];
      shifted = hv_ff << {off, 3'b000};
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_IDLE: if (req.valid) begin
            ctr_in = req.data; state_in = ST_LOAD_I1;
         end
         ST_LOAD_I1: begin
            sha_start = 1'b1; sha_h_in = SHA1_IV; blk = pad_block(key, 8'h36);
            state_in = ST_RUN_I1;
         end
         ST_RUN_I1: if (sha_done) begin
            hv_in = sha_h_out; state_in = ST_LOAD_I2;
         end
         ST_LOAD_I2: begin
            sha_start = 1'b1;
            blk = {ctr_ff, 8'h80, 376'd0, 64'd576};
            state_in = ST_RUN_I2;
         end
         ST_RUN_I2: if (sha_done) begin
            inner_in = sha_h_out; state_in = ST_LOAD_O1;
         end
         ST_LOAD_O1: begin
            sha_start = 1'b1; sha_h_in = SHA1_IV; blk = pad_block(key, 8'h5C);
            state_in = ST_RUN_O1;
         end
         ST_RUN_O1: if (sha_done) begin
            hv_in = sha_h_out; state_in = ST_LOAD_O2;
         end
         ST_LOAD_O2: begin
            sha_start = 1'b1;
            blk = {inner_ff, 8'h80, 280'd0, 64'd672};
            state_in = ST_RUN_O2;
         end
         ST_RUN_O2: if (sha_done) begin
            hv_in = sha_h_out; state_in = ST_TRUNC;
         end
         ST_TRUNC: begin
            if (digits_ff == 4'd6 || digits_ff == 4'd8) begin
               mod_start = 1'b1; state_in = ST_REDUCE;
            end else begin
               code_in = '0; state_in = ST_DONE;
            end
         end
         ST_REDUCE: if (mod_done) begin
            code_in = mod_rem; state_in = ST_DONE;
         end
         ST_DONE: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      ctr_ff <= ctr_in; hv_ff <= hv_in; inner_ff <= inner_in;
      code_ff <= code_in;
   end

   assign rsp.data = code_ff;

   `HOTP_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, !rsp.valid)
   `HOTP_ASSERT_NEXT(a_take_load, clock, reset, req.valid && req.ready, state_ff == ST_LOAD_I1)
   `HOTP_ASSERT_IMP(a_code_range, clock, reset, rsp.valid, rsp.data <= 27'd99999999)
endmodule

FILE: bench/hotp_code_generator_top_tb.sv
// Self-checking testbench for the HOTP code generator: HMAC-SHA1 predictor, random traffic
`timescale 1ns / 100ps
module hotp_code_generator_top_tb;
   import hotp_pkg::*;

   localparam int CYCLE_LIMIT  = 3000000;
   localparam int SETTLE_TICKS = 400;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   hotp_if #(.WIDTH(CTR_W))  req_ch ();
   hotp_if #(.WIDTH(CODE_W)) rsp_ch ();

   hotp_code_generator_top u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   logic [159:0] shadow_key;
   logic [3:0]   shadow_digits;
   logic [CODE_W-1:0] expected_codes[$];
   int  mismatches;
   int  cycles;
   bit  calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                  input logic [511:0] blk);
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
   endfunction

   function automatic logic [CODE_W-1:0] predict_code(input logic [63:0] ctr,
                                                      input logic [159:0] key,
                                                      input logic [3:0] digits);
      logic [159:0] inner, mac;
      logic [3:0]   off;
      logic [31:0]  bin;
      inner = sha1_compress(SHA1_IV, {key ^ {20{8'h36}}, {44{8'h36}}});
      inner = sha1_compress(inner, {ctr, 8'h80, 376'b0, 64'd576});
      mac   = sha1_compress(SHA1_IV, {key ^ {20{8'h5C}}, {44{8'h5C}}});
      mac   = sha1_compress(mac, {inner, 8'h80, 280'b0, 64'd672});
      off   = mac[3:0];
      bin   = mac[159 - 8*off -: 32] & 32'h7FFFFFFF;
      if (digits == 4'd6) bin = bin % MOD6;
      else if (digits == 4'd8) bin = bin % MOD8;
      else bin = '0;
      return bin[CODE_W-1:0];
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("hotp_code_generator_top: mismatch");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ch.ready = calm ? 1'b1 : ($urandom_range(99) >= 35);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected code %0d", rsp_ch.data);
         end else begin
            if (rsp_ch.data !== expected_codes[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("code mismatch: expected %0d actual %0d",
                           expected_codes[0], rsp_ch.data);
            end
            void'(expected_codes.pop_front());
         end
      end
   end

   task automatic wait_drained();
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         REG_KEY0:   shadow_key[159:96] = value;
         REG_KEY1:   shadow_key[95:32]  = value;
         REG_KEY2:   shadow_key[31:0]   = value[31:0];
         REG_DIGITS: shadow_digits      = value[3:0];
      endcase
   endtask

   task automatic load_setup(input logic [159:0] key, input logic [3:0] digits);
      wait_drained();
      write_csr(REG_KEY0, key[159:96]);
      write_csr(REG_KEY1, key[95:32]);
      write_csr(REG_KEY2, {32'h0, key[31:0]});
      write_csr(REG_DIGITS, {60'h0, digits});
   endtask

   task automatic send_counter(input logic [63:0] ctr);
      @(negedge clock);
      if (!calm) begin
         while ($urandom_range(99) < 35) begin
            req_ch.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid = 1'b1;
      req_ch.data  = ctr;
      do @(posedge clock); while (!req_ch.ready);
      expected_codes.push_back(predict_code(ctr, shadow_key, shadow_digits));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_counter(64'h0);
      send_counter(64'hFFFF_FFFF_FFFF_FFFF);
      send_counter(64'h8000_0000_0000_0000);
      send_counter(64'h1);
      end_burst();
   endtask

   task automatic test_known_key();
      load_setup(160'h3132333435363738393031323334353637383930, 4'd6);
      for (int i = 0; i < 6; i++) send_counter(64'(i));
      end_burst();
      load_setup(shadow_key, 4'd8);
      send_counter(64'h0);
      send_counter(64'h0000_0000_0235_F0F6);
      end_burst();
   endtask

   task automatic test_digit_counts();
      logic [3:0] odd_counts[4] = '{4'd0, 4'd7, 4'd15, 4'd9};
      foreach (odd_counts[i]) begin
         load_setup(shadow_key, odd_counts[i]);
         send_counter({$urandom, $urandom});
         end_burst();
      end
   endtask

   task automatic test_key_extremes();
      load_setup({160{1'b1}}, 4'd8);
      send_counter(64'h0);
      send_counter(64'hFFFF_FFFF_FFFF_FFFF);
      end_burst();
      load_setup(160'h0, 4'd6);
      send_counter(64'h5555_AAAA_5555_AAAA);
      end_burst();
   endtask

   task automatic test_random_traffic();
      logic [3:0] digits;
      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(9))
            0:       digits = 4'($urandom);
            1, 2, 3: digits = 4'd8;
            default: digits = 4'd6;
         endcase
         load_setup({$urandom, $urandom, $urandom, $urandom, $urandom}, digits);
         calm = (phase == 4);
         for (int i = 0; i < 85; i++) send_counter({$urandom, $urandom});
         end_burst();
         calm = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      cycles = 0;
      mismatches = 0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      shadow_key = '0;
      shadow_digits = 4'd6;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_known_key();
      test_digit_counts();
      test_key_extremes();
      test_random_traffic();
      wait_drained();
      if (mismatches == 0) begin
         $display("hotp_code_generator_top: match");
      end else begin
         $display("hotp_code_generator_top: mismatch");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/hotp_pkg.sv
rtl/hotp_if.sv
rtl/hotp_sha1_core.sv
rtl/hotp_mod_unit.sv
rtl/hotp_code_generator_top.sv
bench/hotp_code_generator_top_tb.sv
